// ----- rtl/trd_pkg.sv -----
`default_nettype none
package trd_pkg;

  localparam int MAX_WIDTH       = 512;
  localparam int MAX_HEIGHT      = 512;
  localparam int DEPTH_MAX       = 65535;
  localparam int DEPTH_FRAC_BITS = 8;

  localparam int CFG_W   = 10;
  localparam int XY_W    = 9;
  localparam int COORD_W = 12;
  localparam int DIFF_W  = 13;
  localparam int PROD_W  = 2 * DIFF_W;
  localparam int E_W     = PROD_W + 1;
  localparam int Z_W     = 16;
  localparam int Q_W     = 17;
  localparam int ACC_W   = Z_W + Q_W + 1;
  localparam int WIDE_W  = 48;
  localparam int ADDR_W  = $clog2(MAX_WIDTH * MAX_HEIGHT);
  localparam int DEPTH_W = $clog2(DEPTH_MAX + 1) + DEPTH_FRAC_BITS;
  localparam int ONE_Q16 = 65536;

  localparam logic [DEPTH_W-1:0] DEPTH_TOP =
    DEPTH_W'(64'(DEPTH_MAX) << DEPTH_FRAC_BITS);

  localparam logic [1:0] OP_LOAD   = 2'd0;
  localparam logic [1:0] OP_STEP   = 2'd1;
  localparam logic [1:0] OP_WDEPTH = 2'd2;
  localparam logic [1:0] OP_NONE   = 2'd3;

  typedef struct packed {
    logic [1:0]                opcode;
    logic signed [COORD_W-1:0] v0_x;
    logic signed [COORD_W-1:0] v0_y;
    logic [Z_W-1:0]            v0_z;
    logic signed [COORD_W-1:0] v1_x;
    logic signed [COORD_W-1:0] v1_y;
    logic [Z_W-1:0]            v1_z;
    logic signed [COORD_W-1:0] v2_x;
    logic signed [COORD_W-1:0] v2_y;
    logic [Z_W-1:0]            v2_z;
  } in_t;

  typedef struct packed {
    logic            fragment_pass;
    logic [XY_W-1:0] pixel_x;
    logic [XY_W-1:0] pixel_y;
    logic [Z_W-1:0]  frag_depth;
    logic [Q_W-1:0]  weight_a;
    logic [Q_W-1:0]  weight_b;
    logic [Q_W-1:0]  weight_c;
    logic            last;
  } out_t;

  typedef struct packed {
    logic [CFG_W-1:0] width;
    logic [CFG_W-1:0] height;
  } cfg_t;

  typedef struct packed {
    logic [1:0] kind;
    in_t        word;
  } q_entry_t;

  typedef struct packed {
    logic pop;
    logic clearing;
  } back_stat_t;

  typedef struct packed {
    logic           start;
    logic [E_W-1:0] num_b;
    logic [E_W-1:0] num_c;
    logic [E_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic           done;
    logic [Q_W-1:0] q_b;
    logic [Q_W-1:0] q_c;
  } div_rsp_t;

endpackage
`default_nettype wire

// ----- rtl/trd_front.sv -----
`default_nettype none
module trd_front (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                start,
  output logic                     busy,
  input  wire trd_pkg::in_t        in_word,
  input  wire trd_pkg::back_stat_t stat,
  output logic                     q_valid,
  output trd_pkg::q_entry_t        q_entry
);
  import trd_pkg::*;

  q_entry_t   q_r [2];
  logic [1:0] count_r;
  logic       head_r;
  logic       tail_r;
  logic       push;

  assign busy    = (count_r == 2'd2) || stat.clearing;
  // unused opcode is dropped here and never reaches the back end
  assign push    = start && !busy && (in_word.opcode != OP_NONE);
  assign q_valid = (count_r != 2'd0);
  assign q_entry = q_r[head_r];

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[tail_r].kind <= in_word.opcode;
      q_r[tail_r].word <= in_word;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= 2'd0;
      head_r  <= 1'b0;
      tail_r  <= 1'b0;
    end else begin
      if (push) tail_r <= ~tail_r;
      if (stat.pop) head_r <= ~head_r;
      count_r <= count_r + {1'b0, push} - {1'b0, stat.pop};
    end
  end

endmodule
`default_nettype wire

// ----- rtl/trd_div.sv -----
`default_nettype none
module trd_div (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire trd_pkg::div_req_t req,
  output trd_pkg::div_rsp_t      rsp
);
  import trd_pkg::*;

  localparam int R_W = E_W + 1;

  logic [R_W-1:0] rb_r, rc_r, den_r;
  logic [Q_W-1:0] qb_r, qc_r;
  logic [4:0]     cnt_r;
  logic           busy_r, first_r, done_r;
  logic [R_W-1:0] tb, tc;
  logic           bit_b, bit_c;

  // numerators never exceed the denominator, so the first step is unshifted
  always_comb begin
    tb    = first_r ? rb_r : {rb_r[R_W-2:0], 1'b0};
    tc    = first_r ? rc_r : {rc_r[R_W-2:0], 1'b0};
    bit_b = (tb >= den_r);
    bit_c = (tc >= den_r);
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      rb_r    <= R_W'(req.num_b);
      rc_r    <= R_W'(req.num_c);
      den_r   <= R_W'(req.den);
      qb_r    <= '0;
      qc_r    <= '0;
      first_r <= 1'b1;
    end else if (busy_r) begin
      rb_r    <= bit_b ? tb - den_r : tb;
      rc_r    <= bit_c ? tc - den_r : tc;
      qb_r    <= {qb_r[Q_W-2:0], bit_b};
      qc_r    <= {qc_r[Q_W-2:0], bit_c};
      first_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= 5'(Q_W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 5'd1;
        if (cnt_r == 5'd1) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign rsp.done = done_r;
  assign rsp.q_b  = qb_r;
  assign rsp.q_c  = qc_r;

endmodule
`default_nettype wire

// ----- rtl/trd_back.sv -----
`default_nettype none
module trd_back (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire trd_pkg::cfg_t     cfg,
  input  wire logic              q_valid,
  input  wire trd_pkg::q_entry_t q_entry,
  output trd_pkg::back_stat_t    stat,
  output trd_pkg::div_req_t      div_req,
  input  wire trd_pkg::div_rsp_t div_rsp,
  output logic                   out_valid,
  output trd_pkg::out_t          out_word
);
  import trd_pkg::*;

  localparam logic [4:0] ST_CLEAR  = 5'd0;
  localparam logic [4:0] ST_IDLE   = 5'd1;
  localparam logic [4:0] ST_LOAD0  = 5'd2;
  localparam logic [4:0] ST_LOAD1  = 5'd3;
  localparam logic [4:0] ST_LOAD2  = 5'd4;
  localparam logic [4:0] ST_STEP0  = 5'd5;
  localparam logic [4:0] ST_STEP1  = 5'd6;
  localparam logic [4:0] ST_STEP2  = 5'd7;
  localparam logic [4:0] ST_STEP3  = 5'd8;
  localparam logic [4:0] ST_STEP4  = 5'd9;
  localparam logic [4:0] ST_STEP5  = 5'd10;
  localparam logic [4:0] ST_DIV    = 5'd11;
  localparam logic [4:0] ST_Z0     = 5'd12;
  localparam logic [4:0] ST_Z1     = 5'd13;
  localparam logic [4:0] ST_Z2     = 5'd14;
  localparam logic [4:0] ST_Z3     = 5'd15;
  localparam logic [4:0] ST_WDEPTH = 5'd16;

  localparam int RB_W = XY_W + CFG_W;

  logic [DEPTH_W-1:0] mem [MAX_WIDTH * MAX_HEIGHT];
  logic [DEPTH_W-1:0] rd_r;

  logic [4:0]               state_r;
  logic [ADDR_W-1:0]        clr_r;
  in_t                      cmd_r;
  logic signed [COORD_W-1:0] ax_r, ay_r;
  logic signed [DIFF_W-1:0] abx_r, aby_r, acx_r, acy_r, pax_r, pay_r;
  logic [Z_W-1:0]           za_r, zb_r, zc_r;
  logic signed [PROD_W-1:0] prod_r;
  logic signed [E_W-1:0]    det_r, e1_r, e2_r;
  logic [XY_W-1:0]          lx_r, ly_r, hx_r, hy_r, cx_r, cy_r;
  logic                     active_r;
  logic [ADDR_W-1:0]        idx_r;
  logic [Q_W-1:0]           wa_r, wb_r, wc_r;
  logic [ACC_W-1:0]         acc_r;
  logic                     out_valid_r;
  out_t                     out_r;

  logic [CFG_W-1:0]          eff_w, eff_h, wm1, hm1;
  logic signed [DIFF_W-1:0]  mul_a, mul_b;
  logic signed [PROD_W-1:0]  mul_p;
  logic [Z_W-1:0]            zm_a;
  logic [Q_W-1:0]            zm_b;
  logic [ACC_W-1:0]          zm_p;
  logic signed [COORD_W-1:0] mnx, mny, mxx, mxy;
  logic signed [DIFF_W-1:0]  lo_x, lo_y, hi_x, hi_y;
  logic signed [E_W-1:0]     dn, e1n, e2n;
  logic signed [E_W+1:0]     e0;
  logic                      in_tri;
  logic [XY_W-1:0]           xx, yy;
  logic [RB_W-1:0]           row_base;
  logic [ADDR_W-1:0]         addr_c;
  logic                      wd_ok;
  logic [WIDE_W-1:0]         wd_full;
  logic [DEPTH_W-1:0]        wd_val;
  logic [ACC_W-1:0]          zsh;
  logic [DEPTH_W-1:0]        zcl;
  logic                      zpass;
  logic [Q_W:0]              wa_sum;
  logic [XY_W-1:0]           ncx, ncy;
  logic                      at_end;
  logic                      wr_en;
  logic [ADDR_W-1:0]         wr_addr;
  logic [DEPTH_W-1:0]        wr_data;
  out_t                      miss_word;

  function automatic logic signed [COORD_W-1:0] min3(
    input logic signed [COORD_W-1:0] a, b, c);
    logic signed [COORD_W-1:0] m;
    m = (a < b) ? a : b;
    return (m < c) ? m : c;
  endfunction

  function automatic logic signed [COORD_W-1:0] max3(
    input logic signed [COORD_W-1:0] a, b, c);
    logic signed [COORD_W-1:0] m;
    m = (a > b) ? a : b;
    return (m > c) ? m : c;
  endfunction

  always_comb begin
    if (cfg.width == '0) eff_w = CFG_W'(1);
    else if (cfg.width > CFG_W'(MAX_WIDTH)) eff_w = CFG_W'(MAX_WIDTH);
    else eff_w = cfg.width;
    if (cfg.height == '0) eff_h = CFG_W'(1);
    else if (cfg.height > CFG_W'(MAX_HEIGHT)) eff_h = CFG_W'(MAX_HEIGHT);
    else eff_h = cfg.height;
    wm1 = eff_w - CFG_W'(1);
    hm1 = eff_h - CFG_W'(1);
  end

  // bounding box, clamped to the screen
  always_comb begin
    mnx  = min3(cmd_r.v0_x, cmd_r.v1_x, cmd_r.v2_x);
    mny  = min3(cmd_r.v0_y, cmd_r.v1_y, cmd_r.v2_y);
    mxx  = max3(cmd_r.v0_x, cmd_r.v1_x, cmd_r.v2_x);
    mxy  = max3(cmd_r.v0_y, cmd_r.v1_y, cmd_r.v2_y);
    lo_x = mnx[COORD_W-1] ? '0 : DIFF_W'(mnx);
    lo_y = mny[COORD_W-1] ? '0 : DIFF_W'(mny);
    hi_x = (DIFF_W'(mxx) > $signed({3'b000, wm1})) ? $signed({3'b000, wm1}) : DIFF_W'(mxx);
    hi_y = (DIFF_W'(mxy) > $signed({3'b000, hm1})) ? $signed({3'b000, hm1}) : DIFF_W'(mxy);
  end

  // shared edge multiplier
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_r)
      ST_LOAD1: begin mul_a = abx_r; mul_b = acy_r; end
      ST_LOAD2: begin mul_a = acx_r; mul_b = aby_r; end
      ST_STEP1: begin mul_a = acx_r; mul_b = pay_r; end
      ST_STEP2: begin mul_a = pax_r; mul_b = acy_r; end
      ST_STEP3: begin mul_a = pax_r; mul_b = aby_r; end
      ST_STEP4: begin mul_a = abx_r; mul_b = pay_r; end
      default: begin mul_a = '0; mul_b = '0; end
    endcase
    mul_p = mul_a * mul_b;
  end

  // depth interpolation multiplier
  always_comb begin
    zm_a = '0;
    zm_b = '0;
    case (state_r)
      ST_Z0: begin zm_a = za_r; zm_b = wa_r; end
      ST_Z1: begin zm_a = zb_r; zm_b = wb_r; end
      ST_Z2: begin zm_a = zc_r; zm_b = wc_r; end
      default: begin zm_a = '0; zm_b = '0; end
    endcase
    zm_p = ACC_W'(zm_a) * ACC_W'(zm_b);
  end

  // orientation fix and inside test
  always_comb begin
    if (det_r[E_W-1]) begin
      dn  = -det_r;
      e1n = -e1_r;
      e2n = -e2_r;
    end else begin
      dn  = det_r;
      e1n = e1_r;
      e2n = e2_r;
    end
    e0 = (E_W+2)'(dn) - (E_W+2)'(e1n) - (E_W+2)'(e2n);
    in_tri = (det_r != '0) && !e0[E_W+1] && !e1n[E_W-1] && !e2n[E_W-1] &&
             ({1'b0, cx_r} < eff_w) && ({1'b0, cy_r} < eff_h);
  end

  // pixel address, shared by the step and the depth write
  always_comb begin
    if (state_r == ST_WDEPTH) begin
      xx = cmd_r.v0_x[XY_W-1:0];
      yy = cmd_r.v0_y[XY_W-1:0];
    end else begin
      xx = cx_r;
      yy = cy_r;
    end
    row_base = RB_W'(yy) * RB_W'(eff_w);
    addr_c   = ADDR_W'(row_base + RB_W'(xx));
  end

  always_comb begin
    wd_ok = !cmd_r.v0_x[COORD_W-1] && !cmd_r.v0_y[COORD_W-1] &&
            (cmd_r.v0_x < $signed({2'b00, eff_w})) &&
            (cmd_r.v0_y < $signed({2'b00, eff_h}));
    wd_full = WIDE_W'(cmd_r.v0_z) << DEPTH_FRAC_BITS;
    wd_val  = (wd_full > WIDE_W'(DEPTH_TOP)) ? DEPTH_TOP : DEPTH_W'(wd_full);
  end

  always_comb begin
    zsh    = acc_r >> (16 - DEPTH_FRAC_BITS);
    zcl    = (WIDE_W'(zsh) > WIDE_W'(DEPTH_TOP)) ? DEPTH_TOP : DEPTH_W'(zsh);
    zpass  = (zcl <= rd_r);
    wa_sum = (Q_W+1)'(ONE_Q16) - (Q_W+1)'(div_rsp.q_b) - (Q_W+1)'(div_rsp.q_c);
  end

  // cursor walk: y inner, x outer
  always_comb begin
    ncx    = cx_r;
    ncy    = cy_r;
    at_end = 1'b0;
    if (cy_r < hy_r) begin
      ncy = cy_r + XY_W'(1);
    end else if (cx_r < hx_r) begin
      ncx = cx_r + XY_W'(1);
      ncy = ly_r;
    end else begin
      at_end = 1'b1;
    end
  end

  // result word for a rejected pixel or a step with nothing loaded
  always_comb begin
    miss_word = '0;
    if (state_r == ST_STEP5) begin
      miss_word.pixel_x = cx_r;
      miss_word.pixel_y = cy_r;
      miss_word.last    = at_end;
    end else begin
      miss_word.last = 1'b1;
    end
  end

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = addr_c;
    wr_data = wd_val;
    case (state_r)
      ST_CLEAR: begin
        wr_en   = 1'b1;
        wr_addr = clr_r;
        wr_data = DEPTH_TOP;
      end
      ST_WDEPTH: wr_en = wd_ok;
      ST_Z3: begin
        wr_en   = zpass;
        wr_addr = idx_r;
        wr_data = zcl;
      end
      default: wr_en = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    rd_r <= mem[idx_r];
  end

  assign stat.pop      = (state_r == ST_IDLE) && q_valid;
  assign stat.clearing = (state_r == ST_CLEAR);

  assign div_req.start = (state_r == ST_STEP5) && in_tri;
  assign div_req.num_b = e1n;
  assign div_req.num_c = e2n;
  assign div_req.den   = dn;

  // datapath registers
  always_ff @(posedge clk) begin
    case (state_r)
      ST_IDLE: if (q_valid) cmd_r <= q_entry.word;
      ST_LOAD0: begin
        ax_r  <= cmd_r.v0_x;
        ay_r  <= cmd_r.v0_y;
        abx_r <= DIFF_W'(cmd_r.v1_x) - DIFF_W'(cmd_r.v0_x);
        aby_r <= DIFF_W'(cmd_r.v1_y) - DIFF_W'(cmd_r.v0_y);
        acx_r <= DIFF_W'(cmd_r.v2_x) - DIFF_W'(cmd_r.v0_x);
        acy_r <= DIFF_W'(cmd_r.v2_y) - DIFF_W'(cmd_r.v0_y);
        za_r  <= cmd_r.v0_z;
        zb_r  <= cmd_r.v1_z;
        zc_r  <= cmd_r.v2_z;
        lx_r  <= lo_x[XY_W-1:0];
        ly_r  <= lo_y[XY_W-1:0];
        hx_r  <= hi_x[XY_W-1:0];
        hy_r  <= hi_y[XY_W-1:0];
      end
      ST_LOAD1: prod_r <= mul_p;
      ST_LOAD2: det_r <= E_W'(prod_r) - E_W'(mul_p);
      ST_STEP0: begin
        pax_r <= DIFF_W'(ax_r) - $signed({4'b0000, cx_r});
        pay_r <= DIFF_W'(ay_r) - $signed({4'b0000, cy_r});
      end
      ST_STEP1: prod_r <= mul_p;
      ST_STEP2: e1_r <= E_W'(prod_r) - E_W'(mul_p);
      ST_STEP3: prod_r <= mul_p;
      ST_STEP4: e2_r <= E_W'(prod_r) - E_W'(mul_p);
      ST_STEP5: idx_r <= addr_c;
      ST_DIV: begin
        wb_r <= div_rsp.q_b;
        wc_r <= div_rsp.q_c;
        wa_r <= wa_sum[Q_W-1:0];
      end
      ST_Z0: acc_r <= zm_p;
      ST_Z1: acc_r <= acc_r + zm_p;
      ST_Z2: acc_r <= acc_r + zm_p;
      default: begin end
    endcase
  end

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_r       <= '0;
      active_r    <= 1'b0;
      cx_r        <= '0;
      cy_r        <= '0;
      out_valid_r <= 1'b0;
      out_r       <= '0;
    end else begin
      out_valid_r <= 1'b0;
      case (state_r)
        ST_CLEAR: begin
          clr_r <= clr_r + ADDR_W'(1);
          if (clr_r == '1) state_r <= ST_IDLE;
        end
        ST_IDLE: begin
          if (q_valid) begin
            case (q_entry.kind)
              OP_LOAD:   state_r <= ST_LOAD0;
              OP_WDEPTH: state_r <= ST_WDEPTH;
              OP_STEP: begin
                if (active_r) begin
                  state_r <= ST_STEP0;
                end else begin
                  out_valid_r <= 1'b1;
                  out_r       <= miss_word;
                end
              end
              default: state_r <= ST_IDLE;
            endcase
          end
        end
        ST_LOAD0: begin
          cx_r     <= lo_x[XY_W-1:0];
          cy_r     <= lo_y[XY_W-1:0];
          active_r <= (lo_x <= hi_x) && (lo_y <= hi_y);
          state_r  <= ST_LOAD1;
        end
        ST_LOAD1: state_r <= ST_LOAD2;
        ST_LOAD2: state_r <= ST_IDLE;
        ST_STEP0: state_r <= ST_STEP1;
        ST_STEP1: state_r <= ST_STEP2;
        ST_STEP2: state_r <= ST_STEP3;
        ST_STEP3: state_r <= ST_STEP4;
        ST_STEP4: state_r <= ST_STEP5;
        ST_STEP5: begin
          if (in_tri) begin
            state_r <= ST_DIV;
          end else begin
            out_valid_r <= 1'b1;
            out_r       <= miss_word;
            cx_r        <= ncx;
            cy_r        <= ncy;
            if (at_end) active_r <= 1'b0;
            state_r <= ST_IDLE;
          end
        end
        ST_DIV: if (div_rsp.done) state_r <= ST_Z0;
        ST_Z0: state_r <= ST_Z1;
        ST_Z1: state_r <= ST_Z2;
        ST_Z2: state_r <= ST_Z3;
        ST_Z3: begin
          out_valid_r         <= 1'b1;
          out_r.fragment_pass <= zpass;
          out_r.pixel_x       <= cx_r;
          out_r.pixel_y       <= cy_r;
          out_r.frag_depth    <= Z_W'(zcl >> DEPTH_FRAC_BITS);
          out_r.weight_a      <= wa_r;
          out_r.weight_b      <= wb_r;
          out_r.weight_c      <= wc_r;
          out_r.last          <= at_end;
          cx_r                <= ncx;
          cy_r                <= ncy;
          if (at_end) active_r <= 1'b0;
          state_r <= ST_IDLE;
        end
        ST_WDEPTH: state_r <= ST_IDLE;
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_r;

endmodule
`default_nettype wire

// ----- rtl/triangle_raster_depth_test.sv -----
`default_nettype none
// Triangle rasterizer with a 512x512 depth store. After reset the block runs a
// clearing pass over all 262144 entries (one depth entry a cycle) with busy high; APB
// writes are taken meanwhile. Commands enter a two-word queue and a sequencer
// executes them one at a time. A step inside the triangle waits on the
// two-lane restoring divider for the barycentric weights, then runs the depth
// multiply-accumulate and the depth store read-modify-write.
// Each result appears on out_word for exactly one cycle with out_valid high;
// the receiver cannot stall, so it must take every result as it comes.
module triangle_raster_depth_test (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         start,
  output logic              busy,
  input  wire trd_pkg::in_t in_word,
  output logic              out_valid,
  output trd_pkg::out_t     out_word,
  input  wire logic         psel,
  input  wire logic         penable,
  input  wire logic         pwrite,
  input  wire logic [2:0]   paddr,
  input  wire logic [31:0]  pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);
  import trd_pkg::*;

  logic [CFG_W-1:0] width_r, height_r;
  cfg_t             cfg;
  back_stat_t       stat;
  logic             q_valid;
  q_entry_t         q_entry;
  div_req_t         div_req;
  div_rsp_t         div_rsp;

  assign pready = 1'b1;
  assign prdata = paddr[2] ? 32'(height_r) : 32'(width_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= CFG_W'(MAX_WIDTH);
      height_r <= CFG_W'(MAX_HEIGHT);
    end else if (psel && penable && pwrite) begin
      if (paddr[2]) height_r <= pwdata[CFG_W-1:0];
      else width_r <= pwdata[CFG_W-1:0];
    end
  end

  assign cfg.width  = width_r;
  assign cfg.height = height_r;

  trd_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start),
    .busy    (busy),
    .in_word (in_word),
    .stat    (stat),
    .q_valid (q_valid),
    .q_entry (q_entry)
  );

  trd_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  trd_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .q_valid   (q_valid),
    .q_entry   (q_entry),
    .stat      (stat),
    .div_req   (div_req),
    .div_rsp   (div_rsp),
    .out_valid (out_valid),
    .out_word  (out_word)
  );

  a_no_result_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !stat.clearing)
    else $error("result during depth clear");

  a_busy_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    stat.clearing |-> busy)
    else $error("input open during depth clear");

  a_div_not_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    div_rsp.done |-> !stat.clearing && !stat.pop)
    else $error("divider finished outside a pixel step");

endmodule
`default_nettype wire
